@@ design/rsie_pkg.sv @@
`default_nettype none

package rsie_pkg;

  localparam int MEM_WORDS = 256;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int PC_BITS   = 16;
  localparam int XLEN      = 32;
  localparam int REG_AW    = 5;

  // request kinds on the input channel
  localparam logic [2:0] FN_EXEC    = 3'd0;
  localparam logic [2:0] FN_SET_REG = 3'd1;
  localparam logic [2:0] FN_SET_MEM = 3'd2;
  localparam logic [2:0] FN_GET_REG = 3'd3;
  localparam logic [2:0] FN_GET_MEM = 3'd4;

  // primary opcodes
  localparam logic [5:0] OP_RTYPE = 6'b000000;
  localparam logic [5:0] OP_BEQ   = 6'b000100;
  localparam logic [5:0] OP_BNE   = 6'b000101;
  localparam logic [5:0] OP_ADDI  = 6'b001000;
  localparam logic [5:0] OP_LW    = 6'b100011;
  localparam logic [5:0] OP_SW    = 6'b101011;

  // R-type function codes
  localparam logic [5:0] FC_ADD = 6'b100000;
  localparam logic [5:0] FC_SUB = 6'b100010;
  localparam logic [5:0] FC_SLT = 6'b101010;

  // execute-stage result, carried into the memory stage
  typedef struct packed {
    logic                rf_we;
    logic [REG_AW-1:0]   rf_idx;
    logic [XLEN-1:0]     rf_data;
    logic                ld;
    logic                mem_we;
    logic [MEM_AW-1:0]   mem_idx;
    logic [XLEN-1:0]     mem_data;
    logic [PC_BITS-1:0]  pc;
    logic [XLEN-1:0]     rd_data;
    logic                rd_mem;
    logic                rd_ok;
    logic                reg_written;
    logic [REG_AW-1:0]   dest;
    logic [XLEN-1:0]     wdata;
    logic                mem_written;
    logic [7:0]          mem_index;
    logic                taken;
    logic                bad;
  } exec_res_t;

  typedef struct packed {
    logic [15:0]       next_pc;
    logic [XLEN-1:0]   read_data;
    logic              reg_written;
    logic [REG_AW-1:0] dest_reg;
    logic [XLEN-1:0]   write_data;
    logic              mem_written;
    logic [7:0]        mem_index;
    logic              branch_taken;
    logic              bad_instruction;
  } out_t;

endpackage

`default_nettype wire

@@ design/rsie_if.sv @@
`default_nettype none

interface rsie_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [31:0]        instr_word;
  logic [7:0]         target_index;
  logic signed [31:0] preset_value;

  modport source (output valid, func, instr_word, target_index, preset_value,
                  input ready);
  modport sink   (input valid, func, instr_word, target_index, preset_value,
                  output ready);
endinterface

interface rsie_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        next_pc;
  logic signed [31:0] read_data;
  logic               reg_written;
  logic [4:0]         dest_reg;
  logic signed [31:0] write_data;
  logic               mem_written;
  logic [7:0]         mem_index;
  logic               branch_taken;
  logic               bad_instruction;

  modport source (output valid, next_pc, read_data, reg_written, dest_reg, write_data,
                  mem_written, mem_index, branch_taken, bad_instruction,
                  input ready);
  modport sink   (input valid, next_pc, read_data, reg_written, dest_reg, write_data,
                  mem_written, mem_index, branch_taken, bad_instruction,
                  output ready);
endinterface

`default_nettype wire

@@ design/rsie_regfile.sv @@
`default_nettype none

// 32 x 32 register file, two registered read ports, one write port.
// Entries never written read as zero; register zero is never stored.
module rsie_regfile
  import rsie_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [REG_AW-1:0] rd_a_idx,
  input  wire logic [REG_AW-1:0] rd_b_idx,
  output logic      [XLEN-1:0]   rd_a_data,
  output logic      [XLEN-1:0]   rd_b_data,
  input  wire logic              we,
  input  wire logic [REG_AW-1:0] wr_idx,
  input  wire logic [XLEN-1:0]   wr_data
);

  logic [XLEN-1:0]        mem_r [2**REG_AW];
  logic [2**REG_AW-1:0]   vld_r;
  logic [XLEN-1:0]        a_q_r, b_q_r;
  logic                   a_v_r, b_v_r;

  always_ff @(posedge clk) begin
    if (we && wr_idx != '0) begin
      mem_r[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      a_q_r <= mem_r[rd_a_idx];
      b_q_r <= mem_r[rd_b_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (we && wr_idx != '0) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        a_v_r <= vld_r[rd_a_idx];
        b_v_r <= vld_r[rd_b_idx];
      end
    end
  end

  assign rd_a_data = a_v_r ? a_q_r : '0;
  assign rd_b_data = b_v_r ? b_q_r : '0;

endmodule

`default_nettype wire

@@ design/rsie_dmem.sv @@
`default_nettype none

// Data memory, one registered read port and one write port, read-first.
// Words never written read as zero (one valid flop per word).
module rsie_dmem
  import rsie_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [MEM_AW-1:0] rd_idx,
  output logic      [XLEN-1:0]   rd_data,
  input  wire logic              we,
  input  wire logic [MEM_AW-1:0] wr_idx,
  input  wire logic [XLEN-1:0]   wr_data
);

  logic [XLEN-1:0]    mem_r [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld_r;
  logic [XLEN-1:0]    q_r;
  logic               q_v_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      q_v_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        q_v_r <= vld_r[rd_idx];
      end
    end
  end

  assign rd_data = q_v_r ? q_r : '0;

endmodule

`default_nettype wire

@@ design/rsie_exec.sv @@
`default_nettype none

// Decode and execute: ALU, branch compare, address add, PC update.
module rsie_exec
  import rsie_pkg::*;
(
  input  wire logic [2:0]         func,
  input  wire logic [31:0]        instr_word,
  input  wire logic [7:0]         target_index,
  input  wire logic [XLEN-1:0]    preset_value,
  input  wire logic [XLEN-1:0]    op_a,
  input  wire logic [XLEN-1:0]    op_b,
  input  wire logic [PC_BITS-1:0] pc,
  output exec_res_t               res
);

  logic [5:0]         op;
  logic [5:0]         fc;
  logic [REG_AW-1:0]  rt;
  logic [REG_AW-1:0]  rd;
  logic [XLEN-1:0]    off;
  logic [XLEN-1:0]    addr;
  logic [MEM_AW-1:0]  midx;
  logic [PC_BITS-1:0] pc_inc;
  logic               reg_ok;
  logic               mem_ok;

  assign op     = instr_word[31:26];
  assign fc     = instr_word[5:0];
  assign rt     = instr_word[20:16];
  assign rd     = instr_word[15:11];
  assign off    = {{16{instr_word[15]}}, instr_word[15:0]};
  assign addr   = op_a + off;
  assign midx   = addr[MEM_AW+1:2];
  assign pc_inc = pc + PC_BITS'(1);
  assign reg_ok = (target_index[7:5] == 3'b000);
  assign mem_ok = (32'(target_index) < 32'(MEM_WORDS));

  always_comb begin
    res    = '0;
    res.pc = pc;
    unique case (func)
      FN_EXEC: begin
        res.pc = pc_inc;
        unique case (op) inside
          OP_RTYPE: begin
            unique case (fc)
              FC_ADD:  res.wdata = op_a + op_b;
              FC_SUB:  res.wdata = op_a - op_b;
              FC_SLT:  res.wdata = {31'd0, ($signed(op_a) < $signed(op_b))};
              default: res.bad = 1'b1;
            endcase
            if (!res.bad) begin
              res.reg_written = 1'b1;
              res.dest        = rd;
              res.rf_we       = 1'b1;
              res.rf_idx      = rd;
              res.rf_data     = res.wdata;
            end
          end
          OP_ADDI: begin
            res.wdata       = addr;
            res.reg_written = 1'b1;
            res.dest        = rt;
            res.rf_we       = 1'b1;
            res.rf_idx      = rt;
            res.rf_data     = addr;
          end
          OP_LW: begin
            res.ld          = 1'b1;
            res.reg_written = 1'b1;
            res.dest        = rt;
            res.rf_we       = 1'b1;
            res.rf_idx      = rt;
            res.mem_idx     = midx;
            res.mem_index   = 8'(midx);
          end
          OP_SW: begin
            res.wdata       = op_b;
            res.mem_we      = 1'b1;
            res.mem_written = 1'b1;
            res.mem_idx     = midx;
            res.mem_data    = op_b;
            res.mem_index   = 8'(midx);
          end
          OP_BEQ, OP_BNE: begin
            res.taken = (op == OP_BEQ) ? (op_a == op_b) : (op_a != op_b);
            if (res.taken) begin
              res.pc = pc_inc + off[PC_BITS-1:0];
            end
          end
          default: res.bad = 1'b1;
        endcase
      end
      FN_SET_REG: begin
        res.rf_we   = reg_ok;
        res.rf_idx  = target_index[REG_AW-1:0];
        res.rf_data = preset_value;
      end
      FN_SET_MEM: begin
        res.mem_we   = mem_ok;
        res.mem_idx  = MEM_AW'(target_index);
        res.mem_data = preset_value;
      end
      FN_GET_REG: begin
        res.rd_data = reg_ok ? op_a : '0;
      end
      FN_GET_MEM: begin
        res.rd_mem  = 1'b1;
        res.rd_ok   = mem_ok;
        res.mem_idx = MEM_AW'(target_index);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ design/risc_subset_instruction_executor.sv @@
// After its request is accepted, a result passes register read, execute, memory stage
// and output register.
// Throughput: one request per cycle unless the output stalls; back-to-back dependent
// instructions are served by bypass from the memory stage and last-write registers.
// Reset (rst_n, synchronous, active low): PC, pipeline valids and all valid bits of
// register file and data memory clear; no clearing pass, accepts requests at once.
`default_nettype none

module risc_subset_instruction_executor
  import rsie_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  rsie_in_if.sink     in_if,
  rsie_out_if.source  out_if
);

  // ---------------------------------------------------------------------------
  // Pipeline control. S1 = execute, S2 = memory/writeback, then output register.
  // Each stage moves when the one after it has room, so the input keeps
  // filling while a finished result waits on the output.
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, out_valid_r;
  logic s2_ready, s1_go, s2_go, in_fire;

  assign s2_ready    = !s2_v_r || !out_valid_r || out_if.ready;
  assign s1_go       = s1_v_r && s2_ready;
  assign s2_go       = s2_v_r && s2_ready;
  assign in_if.ready = !s1_v_r || s2_ready;
  assign in_fire     = in_if.valid && in_if.ready;

  // S1 request registers
  logic [2:0]        s1_func_r;
  logic [31:0]       s1_iw_r;
  logic [7:0]        s1_tgt_r;
  logic [XLEN-1:0]   s1_pval_r;

  // S2 registers
  exec_res_t         s2_r;

  // output register
  out_t              out_r;

  logic [PC_BITS-1:0] pc_r;

  // last register-file write, covers the read-versus-write race at one edge
  logic              rrec_v_r;
  logic [REG_AW-1:0] rrec_idx_r;
  logic [XLEN-1:0]   rrec_data_r;

  // last memory write, same purpose for the data memory
  logic              mrec_v_r;
  logic [MEM_AW-1:0] mrec_idx_r;
  logic [XLEN-1:0]   mrec_data_r;

  // ---------------------------------------------------------------------------
  // Register file: read at accept. Port A serves rs, or the target on a
  // read-register request.
  // ---------------------------------------------------------------------------
  logic [REG_AW-1:0] in_a_idx;
  logic [XLEN-1:0]   rf_a_q, rf_b_q;
  logic              rf_we;
  logic [XLEN-1:0]   wb_data;

  assign in_a_idx = (in_if.func == FN_GET_REG) ? in_if.target_index[REG_AW-1:0]
                                              : in_if.instr_word[25:21];
  assign rf_we    = s2_go && s2_r.rf_we;

  rsie_regfile u_rf (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_fire),
    .rd_a_idx  (in_a_idx),
    .rd_b_idx  (in_if.instr_word[20:16]),
    .rd_a_data (rf_a_q),
    .rd_b_data (rf_b_q),
    .we        (rf_we),
    .wr_idx    (s2_r.rf_idx),
    .wr_data   (wb_data)
  );

  // ---------------------------------------------------------------------------
  // S1 operand bypass: S2 result first (younger), then last write, then array.
  // Register zero always reads zero, never bypassed.
  // ---------------------------------------------------------------------------
  logic [REG_AW-1:0] s1_a_idx, s1_b_idx;
  logic [XLEN-1:0]   op_a, op_b;

  assign s1_a_idx = (s1_func_r == FN_GET_REG) ? s1_tgt_r[REG_AW-1:0] : s1_iw_r[25:21];
  assign s1_b_idx = s1_iw_r[20:16];

  always_comb begin
    if (s2_v_r && s2_r.rf_we && s2_r.rf_idx == s1_a_idx && s1_a_idx != '0) begin
      op_a = wb_data;
    end else if (rrec_v_r && rrec_idx_r == s1_a_idx) begin
      op_a = rrec_data_r;
    end else begin
      op_a = rf_a_q;
    end
    if (s2_v_r && s2_r.rf_we && s2_r.rf_idx == s1_b_idx && s1_b_idx != '0) begin
      op_b = wb_data;
    end else if (rrec_v_r && rrec_idx_r == s1_b_idx) begin
      op_b = rrec_data_r;
    end else begin
      op_b = rf_b_q;
    end
  end

  exec_res_t s1_res;

  rsie_exec u_exec (
    .func         (s1_func_r),
    .instr_word   (s1_iw_r),
    .target_index (s1_tgt_r),
    .preset_value (s1_pval_r),
    .op_a         (op_a),
    .op_b         (op_b),
    .pc           (pc_r),
    .res          (s1_res)
  );

  // ---------------------------------------------------------------------------
  // Data memory: read as S1 moves to S2, written as S2 leaves.
  // A store leaving at the same edge is picked up from the last-write record.
  // ---------------------------------------------------------------------------
  logic [XLEN-1:0] dm_q, ld_val;
  logic            dm_we;

  assign dm_we = s2_go && s2_r.mem_we;

  rsie_dmem u_dmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (s1_go),
    .rd_idx  (s1_res.mem_idx),
    .rd_data (dm_q),
    .we      (dm_we),
    .wr_idx  (s2_r.mem_idx),
    .wr_data (s2_r.mem_data)
  );

  assign ld_val  = (mrec_v_r && mrec_idx_r == s2_r.mem_idx) ? mrec_data_r : dm_q;
  assign wb_data = s2_r.ld ? ld_val : s2_r.rf_data;

  // ---------------------------------------------------------------------------
  // Output formatting
  // ---------------------------------------------------------------------------
  out_t s2_out;

  always_comb begin
    s2_out.next_pc         = 16'(s2_r.pc);
    s2_out.read_data       = s2_r.rd_mem ? (s2_r.rd_ok ? ld_val : '0) : s2_r.rd_data;
    s2_out.reg_written     = s2_r.reg_written;
    s2_out.dest_reg        = s2_r.dest;
    s2_out.write_data      = s2_r.ld ? ld_val : s2_r.wdata;
    s2_out.mem_written     = s2_r.mem_written;
    s2_out.mem_index       = s2_r.mem_index;
    s2_out.branch_taken    = s2_r.taken;
    s2_out.bad_instruction = s2_r.bad;
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r <= in_if.func;
      s1_iw_r   <= in_if.instr_word;
      s1_tgt_r  <= in_if.target_index;
      s1_pval_r <= in_if.preset_value;
    end
    if (s1_go) begin
      s2_r <= s1_res;
    end
    if (s2_go) begin
      out_r <= s2_out;
    end
    if (rf_we && s2_r.rf_idx != '0) begin
      rrec_idx_r  <= s2_r.rf_idx;
      rrec_data_r <= wb_data;
    end
    if (dm_we) begin
      mrec_idx_r  <= s2_r.mem_idx;
      mrec_data_r <= s2_r.mem_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      rrec_v_r    <= 1'b0;
      mrec_v_r    <= 1'b0;
    end else begin
      if (in_if.ready) begin
        s1_v_r <= in_if.valid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
      if (s2_go) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_go) begin
        pc_r <= s1_res.pc;
      end
      if (rf_we && s2_r.rf_idx != '0) begin
        rrec_v_r <= 1'b1;
      end
      if (dm_we) begin
        mrec_v_r <= 1'b1;
      end
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.next_pc         = out_r.next_pc;
  assign out_if.read_data       = out_r.read_data;
  assign out_if.reg_written     = out_r.reg_written;
  assign out_if.dest_reg        = out_r.dest_reg;
  assign out_if.write_data      = out_r.write_data;
  assign out_if.mem_written     = out_r.mem_written;
  assign out_if.mem_index       = out_r.mem_index;
  assign out_if.branch_taken    = out_r.branch_taken;
  assign out_if.bad_instruction = out_r.bad_instruction;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (pc_r == '0 && !s1_v_r && !s2_v_r && !out_valid_r))
    else $error("reset did not clear pipeline state");

  a_s1_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_go) |-> (s2_v_r && out_valid_r && !out_if.ready))
    else $error("execute stage held without a downstream stall");

  a_bad_no_side_effect: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && s2_r.bad) |-> (!s2_r.rf_we && !s2_r.mem_we && !s2_r.taken))
    else $error("unsupported instruction carries a side effect");

  a_one_target: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> !(s2_r.rf_we && s2_r.mem_we))
    else $error("request writes both register file and memory");

endmodule

`default_nettype wire
